// ----- sv/tiu_pkg.sv -----
// Shared types, codes and constants of the texture upscaler.
package tiu_pkg;

  // Default store geometry
  localparam int unsigned MAX_SRC_WIDTH_DEF  = 128;
  localparam int unsigned MAX_SRC_HEIGHT_DEF = 128;

  // Queue between front and back, and the most requests that can be in flight
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned MAX_INFLIGHT = QUEUE_DEPTH + 2;

  // Field widths
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SRC_COORD_W = 7;
  localparam int unsigned OUT_COORD_W = 9;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned TEXEL_W     = 8;
  localparam int unsigned WEIGHT_W    = 5;
  localparam int unsigned SUM_W       = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BILINEAR    = 2'd3;

  // Scale codes
  localparam logic [1:0] SHIFT_X1   = 2'd0;
  localparam logic [1:0] SHIFT_X2   = 2'd1;
  localparam logic [1:0] SHIFT_X4   = 2'd2;
  localparam logic [1:0] SHIFT_RSVD = 2'd3;

  // Transaction modes
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Weight of a single texel in nearest mode (all of the 4x4 quarter grid)
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 5'd16;

  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
    logic [1:0] shift;
    logic       bilinear;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    width:    8'd128,
    height:   8'd128,
    shift:    SHIFT_X2,
    bilinear: 1'b0
  };

  // One classified operation, as queued between front and back
  typedef struct packed {
    logic                is_write;
    logic                oor;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [TEXEL_W-1:0]  texel;
    logic                clamp_x;
    logic                clamp_y;
    logic [WEIGHT_W-1:0] w_tl;
    logic [WEIGHT_W-1:0] w_tr;
    logic [WEIGHT_W-1:0] w_bl;
    logic [WEIGHT_W-1:0] w_br;
  } op_t;

endpackage

// ----- sv/tiu_req_if.sv -----
// Input channel: texel writes and pixel requests.
interface tiu_req_if import tiu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SRC_COORD_W-1:0] src_col;
  logic [SRC_COORD_W-1:0] src_row;
  logic [TEXEL_W-1:0]     texel;
  logic [OUT_COORD_W-1:0] out_col;
  logic [OUT_COORD_W-1:0] out_row;

  modport source (output valid, mode, src_col, src_row, texel, out_col, out_row,
                  input ready);
  modport sink   (input valid, mode, src_col, src_row, texel, out_col, out_row,
                  output ready);
endinterface

// ----- sv/tiu_rsp_if.sv -----
// Output channel: upscaled pixels.
interface tiu_rsp_if import tiu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] pixel;
  logic               out_of_range;

  modport source (output valid, pixel, out_of_range, input ready);
  modport sink   (input valid, pixel, out_of_range, output ready);
endinterface

// ----- sv/tiu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tiu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tiu_fifo.sv -----
// Small in-order queue of classified operations between front and back.
module tiu_fifo import tiu_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  op_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Pointer wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, payload only
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign op_o    = mem_q[rd_ptr_q];

endmodule

// ----- sv/tiu_front.sv -----
// Front end: accepts transactions, range-checks requests and derives coordinates and weights.
module tiu_front import tiu_pkg::*; #(
  parameter int unsigned MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF
) (
  input  cfg_t           cfg_i,
  tiu_req_if.sink        req_i,
  input  logic           q_full_i,
  output logic           push_o,
  output op_t            op_o
);

  localparam logic [10:0] MaxW = 11'(MAX_SRC_WIDTH);
  localparam logic [10:0] MaxH = 11'(MAX_SRC_HEIGHT);

  logic [7:0] w_eff, h_eff;
  logic [9:0] w_scaled, h_scaled;
  logic [8:0] x0_full, y0_full;
  logic [7:0] x0, y0;
  logic       oor, clamp_x, clamp_y, beyond;
  logic [1:0] qx, qy;
  logic [2:0] wx_lo, wx_hi, wy_lo, wy_hi;
  logic       accept;

  function automatic logic [WEIGHT_W-1:0] weight(input logic [2:0] a, input logic [2:0] b);
    logic [5:0] p;
    p = {3'b000, a} * {3'b000, b};
    return p[WEIGHT_W-1:0];
  endfunction

  // Dimensions in use, saturated to the store size
  always_comb begin
    w_eff = ({3'b000, cfg_i.width} > MaxW) ? MaxW[7:0] : cfg_i.width;
    h_eff = ({3'b000, cfg_i.height} > MaxH) ? MaxH[7:0] : cfg_i.height;
  end

  // Frame check and source coordinates
  assign w_scaled = {2'b00, w_eff} << cfg_i.shift;
  assign h_scaled = {2'b00, h_eff} << cfg_i.shift;
  assign oor      = ({1'b0, req_i.out_col} >= w_scaled) || ({1'b0, req_i.out_row} >= h_scaled);
  assign x0_full  = req_i.out_col >> cfg_i.shift;
  assign y0_full  = req_i.out_row >> cfg_i.shift;
  assign x0       = x0_full[7:0];
  assign y0       = y0_full[7:0];
  assign clamp_x  = ({1'b0, x0} + 9'd1) >= {1'b0, w_eff};
  assign clamp_y  = ({1'b0, y0} + 9'd1) >= {1'b0, h_eff};

  // Fraction in quarters
  always_comb begin
    unique case (cfg_i.shift)
      SHIFT_X1: begin
        qx = 2'b00;
        qy = 2'b00;
      end
      SHIFT_X2: begin
        qx = {req_i.out_col[0], 1'b0};
        qy = {req_i.out_row[0], 1'b0};
      end
      SHIFT_X4: begin
        qx = req_i.out_col[1:0];
        qy = req_i.out_row[1:0];
      end
      default: begin
        qx = 2'b00;
        qy = 2'b00;
      end
    endcase
  end

  assign wx_lo = 3'd4 - {1'b0, qx};
  assign wx_hi = {1'b0, qx};
  assign wy_lo = 3'd4 - {1'b0, qy};
  assign wy_hi = {1'b0, qy};

  // Texel writes outside the store are dropped
  assign beyond = ({4'b0000, req_i.src_col} >= MaxW) || ({4'b0000, req_i.src_row} >= MaxH);

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign push_o      = accept && ((req_i.mode == MODE_REQUEST) || !beyond);

  // Classified operation; nearest mode folds every neighbor onto the top-left texel
  always_comb begin
    op_o = '0;
    if (req_i.mode == MODE_WRITE) begin
      op_o.is_write = 1'b1;
      op_o.col      = {1'b0, req_i.src_col};
      op_o.row      = {1'b0, req_i.src_row};
      op_o.texel    = req_i.texel;
    end else begin
      op_o.oor     = oor;
      op_o.col     = x0;
      op_o.row     = y0;
      op_o.clamp_x = clamp_x || !cfg_i.bilinear;
      op_o.clamp_y = clamp_y || !cfg_i.bilinear;
      if (cfg_i.bilinear) begin
        op_o.w_tl = weight(wy_lo, wx_lo);
        op_o.w_tr = weight(wy_lo, wx_hi);
        op_o.w_bl = weight(wy_hi, wx_lo);
        op_o.w_br = weight(wy_hi, wx_hi);
      end else begin
        op_o.w_tl = WEIGHT_FULL;
      end
    end
  end

endmodule

// ----- sv/tiu_back.sv -----
// Back end: four-bank texel store, 2x2 fetch, weighted sum and output register.
module tiu_back import tiu_pkg::*; #(
  parameter int unsigned MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  op_t       op_i,
  output logic      q_pop_o,
  tiu_rsp_if.source rsp_o
);

  // Banks split the store by row and column parity
  localparam int unsigned HalfW     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int unsigned HalfH     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int unsigned BankDepth = HalfW * HalfH;
  localparam int unsigned AddrW     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int unsigned CalcW     = 18;

  function automatic logic [AddrW-1:0] bank_addr(input logic [6:0] rh, input logic [6:0] ch);
    logic [CalcW-1:0] full;
    full = {11'd0, rh} * CalcW'(HalfW) + {11'd0, ch};
    return full[AddrW-1:0];
  endfunction

  logic [8:0]         row_p1, col_p1;
  logic [6:0]         rh_even, rh_odd, ch_even, ch_odd;
  logic [AddrW-1:0]   addr [4];
  logic [3:0]         bank_we;
  logic [TEXEL_W-1:0] bank_data [4];
  logic               rd_issue, advance, s1_free;
  logic               s1_valid_q, s1_valid_d;
  op_t                s1_op_q;
  logic               out_valid_q;
  logic [TEXEL_W-1:0] pixel_q;
  logic               oor_q;
  logic [TEXEL_W-1:0] tl, tr, bl, br;
  logic [SUM_W-1:0]   sum;

  // Half-resolution coordinates: even neighbor sits at (c+1)>>1, odd one at c>>1
  assign row_p1  = {1'b0, op_i.row} + 9'd1;
  assign col_p1  = {1'b0, op_i.col} + 9'd1;
  assign rh_even = row_p1[7:1];
  assign rh_odd  = op_i.row[7:1];
  assign ch_even = col_p1[7:1];
  assign ch_odd  = op_i.col[7:1];

  // Issue: writes go any time, reads need room in the read stage
  assign advance  = !out_valid_q || rsp_o.ready;
  assign s1_free  = !s1_valid_q || advance;
  assign q_pop_o  = !q_empty_i && (op_i.is_write || s1_free);
  assign rd_issue = q_pop_o && !op_i.is_write;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign addr[b]    = bank_addr((b / 2 == 1) ? rh_odd : rh_even,
                                  (b % 2 == 1) ? ch_odd : ch_even);
    assign bank_we[b] = q_pop_o && op_i.is_write && ({op_i.row[0], op_i.col[0]} == 2'(b));

    tiu_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (addr[b]),
      .wdata_i (op_i.texel),
      .re_i    (rd_issue),
      .raddr_i (addr[b]),
      .rdata_o (bank_data[b])
    );
  end

  // Read stage control
  always_comb begin
    if (rd_issue) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      s1_op_q <= op_i;
    end
  end

  // Neighborhood select; a clamped neighbor repeats its inner texel
  always_comb begin
    tl = bank_data[{s1_op_q.row[0], s1_op_q.col[0]}];
    tr = s1_op_q.clamp_x ? tl : bank_data[{s1_op_q.row[0], ~s1_op_q.col[0]}];
    bl = s1_op_q.clamp_y ? tl : bank_data[{~s1_op_q.row[0], s1_op_q.col[0]}];
    if (s1_op_q.clamp_x) begin
      br = bl;
    end else if (s1_op_q.clamp_y) begin
      br = tr;
    end else begin
      br = bank_data[{~s1_op_q.row[0], ~s1_op_q.col[0]}];
    end
  end

  // Weights add up to 16, so the sum stays below 4096
  assign sum = {4'd0, tl} * {7'd0, s1_op_q.w_tl} + {4'd0, tr} * {7'd0, s1_op_q.w_tr}
             + {4'd0, bl} * {7'd0, s1_op_q.w_bl} + {4'd0, br} * {7'd0, s1_op_q.w_br};

  // Output register
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      oor_q   <= s1_op_q.oor;
      pixel_q <= s1_op_q.oor ? '0 : sum[SUM_W-1:4];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.pixel        = pixel_q;
  assign rsp_o.out_of_range = oor_q;

endmodule

// ----- sv/texture_integer_upscaler_core.sv -----
// Texture upscaler top level: config registers, front end, operation queue and back end.
// A request's result passes the operation queue, read stage and output register.
// Throughput: one transaction per cycle unless the queue is full, writes and requests
// mixed; each of the four store banks serves one read or one write per cycle, giving
// the 2x2 neighborhood at once. Reset: registers go to 128x128, x2, nearest; queue and
// pipeline empty. The texel store is not cleared and is ready at once.
module texture_integer_upscaler_core import tiu_pkg::*; #(
  parameter int unsigned MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tiu_req_if.sink               req_i,
  tiu_rsp_if.source             rsp_o
);

  cfg_t cfg_q, cfg_d;
  logic push, q_full, q_empty, q_pop;
  op_t  push_op, head_op;

  // Configuration writes; a reserved scale code is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:   cfg_d.width = cfg_wdata_i;
        REG_SRC_HEIGHT:  cfg_d.height = cfg_wdata_i;
        REG_SCALE_SHIFT: begin
          if (cfg_wdata_i[1:0] != SHIFT_RSVD) begin
            cfg_d.shift = cfg_wdata_i[1:0];
          end
        end
        REG_BILINEAR:    cfg_d.bilinear = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tiu_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .cfg_i    (cfg_q),
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (push_op)
  );

  tiu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (head_op)
  );

  tiu_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .op_i      (head_op),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

// ----- sv/tiu_checker.sv -----
// Port-level checks of the texture upscaler and their binding to the top level.
module tiu_checker import tiu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_mode_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [TEXEL_W-1:0] rsp_pixel_i,
  input logic               rsp_oor_i
);

  localparam int unsigned CntW = $clog2(MAX_INFLIGHT + 2);

  logic [CntW-1:0] pending_q, pending_d;
  logic            inc, dec;

  // Requests accepted but not yet answered
  assign inc = req_valid_i && req_ready_i && (req_mode_i == MODE_REQUEST);
  assign dec = rsp_valid_i && rsp_ready_i;

  always_comb begin
    unique case ({inc, dec})
      2'b10:   pending_d = pending_q + CntW'(1);
      2'b01:   pending_d = pending_q - CntW'(1);
      default: pending_d = pending_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != '0)
    else $error("result offered with no request outstanding");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CntW'(MAX_INFLIGHT))
    else $error("more requests in flight than the pipeline can hold");

  a_oor_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_oor_i |-> rsp_pixel_i == '0)
    else $error("out-of-range result with nonzero pixel");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_pixel_i) && $stable(rsp_oor_i))
    else $error("stalled result changed or dropped");

endmodule

bind texture_integer_upscaler_core tiu_checker u_tiu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_mode_i  (req_i.mode),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_pixel_i (rsp_o.pixel),
  .rsp_oor_i   (rsp_o.out_of_range)
);

// ----- bench/tb_texture_integer_upscaler_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the texture integer upscaler core: texel writes, pixel requests.
module tb_texture_integer_upscaler_core;
  import tiu_pkg::*;

  localparam int unsigned STORE_COLS    = MAX_SRC_WIDTH_DEF;
  localparam int unsigned STORE_ROWS    = MAX_SRC_HEIGHT_DEF;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_INFLIGHT + 4;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 80;

  typedef struct packed {
    logic                   mode;
    logic [SRC_COORD_W-1:0] src_col;
    logic [SRC_COORD_W-1:0] src_row;
    logic [TEXEL_W-1:0]     texel;
    logic [OUT_COORD_W-1:0] out_col;
    logic [OUT_COORD_W-1:0] out_row;
  } tex_op_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] pixel;
    logic               out_of_range;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tiu_req_if req_if ();
  tiu_rsp_if rsp_if ();

  // Shadow of the texel store and the registers
  logic [TEXEL_W-1:0] texel_mem     [STORE_COLS*STORE_ROWS];
  bit                 texel_written [STORE_COLS*STORE_ROWS];
  logic [7:0]         cur_width;
  logic [7:0]         cur_height;
  logic [1:0]         cur_shift;
  logic               cur_bilinear;

  pixel_t      pixel_expect_q [$];
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  int unsigned rsp_hold_left;
  int unsigned mismatch_count;
  int unsigned items_sent;

  texture_integer_upscaler_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned eff_dim(input logic [7:0] v, input int unsigned limit);
    return (v > limit) ? limit : int'(v);
  endfunction

  // Expected pixel for a request under the current shadow config
  function automatic pixel_t upscale_pixel(input logic [OUT_COORD_W-1:0] x,
                                           input logic [OUT_COORD_W-1:0] y);
    pixel_t      res;
    int unsigned w, h, x0, y0, x1, y1, qx, qy, tl, tr, bl, br, acc;
    w = eff_dim(cur_width, STORE_COLS);
    h = eff_dim(cur_height, STORE_ROWS);
    res = '0;
    if (x >= (w << cur_shift) || y >= (h << cur_shift)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    x0 = x >> cur_shift;
    y0 = y >> cur_shift;
    if (!cur_bilinear) begin
      acc = texel_mem[y0 * STORE_COLS + x0];
    end else begin
      // right and bottom neighbors clamp to the last column / row in use
      x1 = (x0 + 1 >= w) ? w - 1 : x0 + 1;
      y1 = (y0 + 1 >= h) ? h - 1 : y0 + 1;
      qx = (x & ((1 << cur_shift) - 1)) << (2 - cur_shift);
      qy = (y & ((1 << cur_shift) - 1)) << (2 - cur_shift);
      tl = texel_mem[y0 * STORE_COLS + x0];
      tr = texel_mem[y0 * STORE_COLS + x1];
      bl = texel_mem[y1 * STORE_COLS + x0];
      br = texel_mem[y1 * STORE_COLS + x1];
      acc = ((4 - qy) * (4 - qx) * tl + (4 - qy) * qx * tr
           + qy * (4 - qx) * bl + qy * qx * br) >> 4;
      if (acc > 255) acc = 255;
    end
    res.pixel = TEXEL_W'(acc);
    return res;
  endfunction

  // Update the shadow for one accepted transaction
  function automatic void apply_op(input tex_op_t op);
    int unsigned addr;
    addr = op.src_row * STORE_COLS + op.src_col;
    if (op.mode == MODE_WRITE) begin
      texel_mem[addr]     = op.texel;
      texel_written[addr] = 1'b1;
    end else begin
      pixel_expect_q.push_back(upscale_pixel(op.out_col, op.out_row));
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offer one transaction, with random idle cycles in front; valid stays high after
  task automatic send_op(input tex_op_t op);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= op.mode;
    req_if.src_col <= op.src_col;
    req_if.src_row <= op.src_row;
    req_if.texel   <= op.texel;
    req_if.out_col <= op.out_col;
    req_if.out_row <= op.out_row;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    apply_op(op);
    items_sent++;
  endtask

  task automatic write_texel(input int unsigned col, input int unsigned row,
                             input int unsigned value);
    tex_op_t op;
    op.mode    = MODE_WRITE;
    op.src_col = SRC_COORD_W'(col);
    op.src_row = SRC_COORD_W'(row);
    op.texel   = TEXEL_W'(value);
    op.out_col = OUT_COORD_W'($urandom);
    op.out_row = OUT_COORD_W'($urandom);
    send_op(op);
  endtask

  // Make sure every texel of the 2x2 neighborhood is written before it is read
  task automatic cover_neighbors(input logic [OUT_COORD_W-1:0] x,
                                 input logic [OUT_COORD_W-1:0] y);
    int unsigned w, h, ci, ri;
    int unsigned cols [2];
    int unsigned rows [2];
    w = eff_dim(cur_width, STORE_COLS);
    h = eff_dim(cur_height, STORE_ROWS);
    if (x >= (w << cur_shift) || y >= (h << cur_shift)) return;
    cols[0] = x >> cur_shift;
    rows[0] = y >> cur_shift;
    cols[1] = (cols[0] + 1 >= w) ? w - 1 : cols[0] + 1;
    rows[1] = (rows[0] + 1 >= h) ? h - 1 : rows[0] + 1;
    for (ci = 0; ci < 2; ci++)
      for (ri = 0; ri < 2; ri++)
        if (!texel_written[rows[ri] * STORE_COLS + cols[ci]])
          write_texel(cols[ci], rows[ri], $urandom_range(255));
  endtask

  task automatic request_pixel(input logic [OUT_COORD_W-1:0] x,
                               input logic [OUT_COORD_W-1:0] y);
    tex_op_t op;
    cover_neighbors(x, y);
    op.mode    = MODE_REQUEST;
    op.src_col = SRC_COORD_W'($urandom);
    op.src_row = SRC_COORD_W'($urandom);
    op.texel   = TEXEL_W'($urandom);
    op.out_col = x;
    op.out_row = y;
    send_op(op);
  endtask

  task automatic wait_results_done();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Idle point: results drained and trailing writes retired
  task automatic settle();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:   cur_width  = data;
      REG_SRC_HEIGHT:  cur_height = data;
      REG_SCALE_SHIFT: if (data[1:0] != SHIFT_RSVD) cur_shift = data[1:0];
      REG_BILINEAR:    cur_bilinear = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Upper bits of the narrow registers are junk on purpose
  task automatic set_config(input logic [7:0] width, input logic [7:0] height,
                            input logic [1:0] shift, input logic bilinear);
    settle();
    write_reg(REG_SRC_WIDTH, width);
    write_reg(REG_SRC_HEIGHT, height);
    write_reg(REG_SCALE_SHIFT, {6'($urandom), shift});
    write_reg(REG_BILINEAR, {7'($urandom), bilinear});
  endtask

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(11))
      0:       return 8'd1;
      1:       return 8'd128;
      2:       return 8'($urandom_range(255, 129));
      3:       return 8'd0;
      4:       return 8'($urandom_range(4, 1));
      default: return 8'($urandom_range(128, 1));
    endcase
  endfunction

  // Mostly in-frame requests, biased toward the clamped last column / row
  task automatic random_request();
    int unsigned fw, fh;
    logic [OUT_COORD_W-1:0] x, y;
    fw = eff_dim(cur_width, STORE_COLS) << cur_shift;
    fh = eff_dim(cur_height, STORE_ROWS) << cur_shift;
    if (fw == 0 || fh == 0 || $urandom_range(99) < 12) begin
      x = OUT_COORD_W'($urandom);
      y = OUT_COORD_W'($urandom);
    end else begin
      x = ($urandom_range(4) == 0) ? OUT_COORD_W'(fw - 1) : OUT_COORD_W'($urandom_range(fw - 1));
      y = ($urandom_range(4) == 0) ? OUT_COORD_W'(fh - 1) : OUT_COORD_W'($urandom_range(fh - 1));
    end
    request_pixel(x, y);
  endtask

  task automatic random_item();
    int unsigned w, h;
    w = eff_dim(cur_width, STORE_COLS);
    h = eff_dim(cur_height, STORE_ROWS);
    if ($urandom_range(99) < 30) begin
      // half the writes land in the frame in use, to hit reads right after writes
      if (w != 0 && h != 0 && $urandom_range(1) == 1)
        write_texel($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255));
      else
        write_texel($urandom_range(127), $urandom_range(127), $urandom_range(255));
    end else begin
      random_request();
    end
  endtask

  // Reset config: 128x128, x2, nearest; frame edges and texel extremes
  task automatic test_reset_defaults();
    write_texel(0, 0, 0);
    write_texel(1, 0, 255);
    write_texel(0, 1, 255);
    write_texel(1, 1, 0);
    write_texel(127, 127, 255);
    request_pixel(0, 0);
    request_pixel(3, 1);
    request_pixel(255, 255);
    request_pixel(256, 0);
    request_pixel(0, 256);
    request_pixel(511, 511);
  endtask

  // Saturated sizes, x4 / x2 / x1, bilinear with clamping, reserved shift ignored
  task automatic test_scale_and_filter();
    set_config(8'd255, 8'd255, SHIFT_X4, 1'b1);
    request_pixel(0, 0);
    request_pixel(3, 2);
    request_pixel(6, 5);
    request_pixel(511, 511);
    request_pixel(510, 1);
    settle();
    write_reg(REG_SCALE_SHIFT, {6'd0, SHIFT_RSVD});
    request_pixel(511, 0);
    set_config(8'd2, 8'd2, SHIFT_X2, 1'b1);
    request_pixel(3, 3);
    request_pixel(1, 1);
    set_config(8'd128, 8'd128, SHIFT_X1, 1'b0);
    request_pixel(127, 127);
    request_pixel(128, 0);
    request_pixel(0, 128);
  endtask

  // Zero width or height: every request is out of frame
  task automatic test_empty_frame();
    set_config(8'd0, 8'd128, SHIFT_X2, 1'b0);
    request_pixel(0, 0);
    set_config(8'd128, 8'd0, SHIFT_X1, 1'b1);
    request_pixel(5, 0);
    set_config(8'd0, 8'd0, SHIFT_X4, 1'b0);
    request_pixel(511, 511);
  endtask

  // Long receiver stall fills the block; then the sender waits for a full drain
  task automatic test_backpressure();
    set_config(8'd128, 8'd128, SHIFT_X2, 1'($urandom_range(1)));
    rsp_hold_left = LONG_HOLD;
    repeat (24) random_request();
    wait_results_done();
    repeat (16) random_item();
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned req_pct, input int unsigned rsp_pct);
    int unsigned first_item;
    req_idle_pct = req_pct;
    rsp_idle_pct = rsp_pct;
    repeat (3) begin
      set_config(pick_dim(), pick_dim(), 2'($urandom_range(3)), 1'($urandom_range(1)));
      first_item = items_sent;
      while (items_sent - first_item < PHASE_ITEMS) random_item();
    end
  endtask

  // Receiver: random ready, or a held-off stretch when one is pending
  always @(posedge clk_i) begin
    if (rsp_hold_left != 0) begin
      rsp_hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Compare each result transaction against the oldest expected pixel
  always @(posedge clk_i) begin : check_results
    pixel_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pixel_expect_q.size() == 0) begin
        report_mismatch("result with none expected, pixel", rsp_if.pixel, 0);
      end else begin
        want = pixel_expect_q.pop_front();
        if (rsp_if.pixel !== want.pixel)
          report_mismatch("pixel", rsp_if.pixel, want.pixel);
        if (rsp_if.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", rsp_if.out_of_range, want.out_of_range);
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either channel
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_SRC_WIDTH;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_WRITE;
    req_if.src_col = '0;
    req_if.src_row = '0;
    req_if.texel   = '0;
    req_if.out_col = '0;
    req_if.out_row = '0;
    rsp_if.ready   = 1'b0;
    cur_width      = CFG_RESET.width;
    cur_height     = CFG_RESET.height;
    cur_shift      = CFG_RESET.shift;
    cur_bilinear   = CFG_RESET.bilinear;
    rsp_hold_left  = 0;
    mismatch_count = 0;
    items_sent     = 0;
    req_idle_pct   = 16;
    rsp_idle_pct   = 49;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_scale_and_filter();
    test_empty_frame();
    test_backpressure();
    test_random_traffic(16, 49);
    test_random_traffic(49, 16);
    test_random_traffic(0, 0);

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pixel_expect_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
